/* hdl/minimum_jerk_trajectory_sum_assert.svh */
// Assertion macros shared by the trajectory block.
`ifndef MINIMUM_JERK_TRAJECTORY_SUM_ASSERT_SVH
`define MINIMUM_JERK_TRAJECTORY_SUM_ASSERT_SVH

// When cond holds, resp must hold a fixed number of cycles later.
`define MJT_ASSERT_LATER(label, clock, resetn, cond, cycles, resp) \
    label: assert property (@(posedge clock) disable iff (!resetn) \
        (cond) |-> ##cycles (resp)) else $error("%m: late or missing response");

// When cond holds, past_sig must have been high a fixed number of cycles earlier.
`define MJT_ASSERT_EARLIER(label, clock, resetn, cond, past_sig, cycles) \
    label: assert property (@(posedge clock) disable iff (!resetn) \
        (cond) |-> $past(past_sig, cycles)) else $error("%m: response without a request");

`endif

/* hdl/mjt_pkg.sv */
package mjt_pkg;

    // How one submovement contributes to the sum.
    typedef enum logic [1:0] {
        MODE_ZERO = 2'd0,
        MODE_FULL = 2'd1,
        MODE_RAMP = 2'd2
    } mode_t;

    // Configuration register indexes.
    typedef enum logic [2:0] {
        REG_AMP_FIRST    = 3'd0,
        REG_START_FIRST  = 3'd1,
        REG_SPAN_FIRST   = 3'd2,
        REG_AMP_SECOND   = 3'd3,
        REG_START_SECOND = 3'd4,
        REG_SPAN_SECOND  = 3'd5
    } reg_index_t;

    localparam int unsigned DATA_W = 32;
    localparam int unsigned POS_W  = 33;

endpackage

/* hdl/minimum_jerk_trajectory_sum.sv */
// Minimum-jerk trajectory sum. A pulse on start with a time stamp begins an item; the
// block takes one item every cycle and busy is never raised. The position of each item
// appears on position with done high for exactly one cycle, after an entry stage that
// classifies the time, the divider (a chain of FRAC_BITS cells producing one quotient
// bit each), then four power multiplies, the polynomial, the amplitude scale and the
// final sum. The receiver cannot stall the output. Registers are written through
// wr_en/wr_index/wr_data and must only change while no item is in flight.
`include "minimum_jerk_trajectory_sum_assert.svh"

module minimum_jerk_trajectory_sum #(
    parameter int unsigned NUM_SUBMOVES = 2,
    parameter int unsigned FRAC_BITS    = 16
) (
    input  logic                              clk,
    input  logic                              rst_n,
    input  logic                              start,
    output logic                              busy,
    input  logic [mjt_pkg::DATA_W-1:0]        time_tick,
    output logic                              done,
    output logic signed [mjt_pkg::POS_W-1:0]  position,
    input  logic                              wr_en,
    input  logic [2:0]                        wr_index,
    input  logic [mjt_pkg::DATA_W-1:0]        wr_data
);

    localparam int unsigned LAT = FRAC_BITS + 8;

    logic signed [mjt_pkg::DATA_W-1:0] amp_reg   [0:1];
    logic [mjt_pkg::DATA_W-1:0]        start_reg [0:1];
    logic [mjt_pkg::DATA_W-1:0]        span_reg  [0:1];

    logic signed [mjt_pkg::DATA_W-1:0] contrib [0:NUM_SUBMOVES-1];
    logic signed [mjt_pkg::POS_W-1:0]  sum_next;
    logic signed [mjt_pkg::POS_W-1:0]  position_reg;
    logic [LAT-1:0]                    valid_reg;
    logic [LAT-1:0]                    valid_next;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            amp_reg[0]   <= '0;
            start_reg[0] <= '0;
            span_reg[0]  <= '0;
            amp_reg[1]   <= '0;
            start_reg[1] <= '0;
            span_reg[1]  <= '0;
        end
        else if (wr_en)
        begin
            unique case (mjt_pkg::reg_index_t'(wr_index))
                mjt_pkg::REG_AMP_FIRST:    amp_reg[0]   <= wr_data;
                mjt_pkg::REG_START_FIRST:  start_reg[0] <= wr_data;
                mjt_pkg::REG_SPAN_FIRST:   span_reg[0]  <= wr_data;
                mjt_pkg::REG_AMP_SECOND:   amp_reg[1]   <= wr_data;
                mjt_pkg::REG_START_SECOND: start_reg[1] <= wr_data;
                mjt_pkg::REG_SPAN_SECOND:  span_reg[1]  <= wr_data;
                default: ;
            endcase
        end
    end

    for (genvar k = 0; k < NUM_SUBMOVES; k++) begin : g_lane
        mjt_lane #(
            .FRAC_BITS (FRAC_BITS)
        ) u_lane (
            .clk       (clk),
            .time_tick (time_tick),
            .amp       (amp_reg[k]),
            .start     (start_reg[k]),
            .span      (span_reg[k]),
            .contrib   (contrib[k])
        );
    end

    always_comb
    begin
        sum_next = '0;
        for (int k = 0; k < NUM_SUBMOVES; k++)
        begin
            sum_next = sum_next + mjt_pkg::POS_W'(contrib[k]);
        end
        valid_next = {valid_reg[LAT-2:0], start};
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= '0;
        end
        else
        begin
            valid_reg <= valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        position_reg <= sum_next;
    end

    assign busy     = 1'b0;
    assign done     = valid_reg[LAT-1];
    assign position = position_reg;

    `MJT_ASSERT_LATER(a_start_gives_done, clk, rst_n, start && !busy, LAT, done)
    `MJT_ASSERT_EARLIER(a_done_had_start, clk, rst_n, done, start, LAT)

endmodule

/* hdl/mjt_div_cell.sv */
// One restoring division step: one quotient bit per cell.
module mjt_div_cell #(
    parameter int unsigned FRAC_BITS = 16
) (
    input  logic                       clk,
    input  logic [mjt_pkg::DATA_W-1:0] span,
    input  logic [mjt_pkg::DATA_W-1:0] rem_in,
    input  logic [FRAC_BITS:0]         quo_in,
    input  mjt_pkg::mode_t             mode_in,
    output logic [mjt_pkg::DATA_W-1:0] rem_out,
    output logic [FRAC_BITS:0]         quo_out,
    output mjt_pkg::mode_t             mode_out
);

    logic [mjt_pkg::DATA_W:0]   rem_dbl;
    logic [mjt_pkg::DATA_W:0]   rem_diff;
    logic                       fits;
    logic [mjt_pkg::DATA_W-1:0] rem_reg;
    logic [mjt_pkg::DATA_W-1:0] rem_next;
    logic [FRAC_BITS:0]         quo_reg;
    logic [FRAC_BITS:0]         quo_next;
    mjt_pkg::mode_t             mode_reg;

    always_comb
    begin
        rem_dbl  = {rem_in, 1'b0};
        rem_diff = rem_dbl - {1'b0, span};
        fits     = (rem_dbl >= {1'b0, span});
        // The remainder stays below the divisor, so it fits in 32 bits.
        rem_next = fits ? rem_diff[mjt_pkg::DATA_W-1:0] : rem_dbl[mjt_pkg::DATA_W-1:0];
        quo_next = {quo_in[FRAC_BITS-1:0], fits};
    end

    always_ff @(posedge clk)
    begin
        rem_reg  <= rem_next;
        quo_reg  <= quo_next;
        mode_reg <= mode_in;
    end

    assign rem_out  = rem_reg;
    assign quo_out  = quo_reg;
    assign mode_out = mode_reg;

endmodule

/* hdl/mjt_lane.sv */
// One submovement: classify, divide through a chain of cells, powers, polynomial, scale.
module mjt_lane #(
    parameter int unsigned FRAC_BITS = 16
) (
    input  logic                              clk,
    input  logic [mjt_pkg::DATA_W-1:0]        time_tick,
    input  logic signed [mjt_pkg::DATA_W-1:0] amp,
    input  logic [mjt_pkg::DATA_W-1:0]        start,
    input  logic [mjt_pkg::DATA_W-1:0]        span,
    output logic signed [mjt_pkg::DATA_W-1:0] contrib
);

    localparam int unsigned QW = FRAC_BITS + 1;
    localparam int unsigned PW = FRAC_BITS + 5;
    localparam int unsigned MW = 2 * QW;
    localparam int unsigned AW = mjt_pkg::DATA_W + FRAC_BITS + 2;

    logic [mjt_pkg::DATA_W-1:0] dt;
    logic [mjt_pkg::DATA_W:0]   end_tick;
    logic                       at_end;
    mjt_pkg::mode_t             mode_next;

    logic [mjt_pkg::DATA_W-1:0] rem_c [0:FRAC_BITS];
    logic [QW-1:0]              quo_c [0:FRAC_BITS];
    mjt_pkg::mode_t             mode_c [0:FRAC_BITS];

    logic [QW-1:0] s1_reg, s2_reg, s3a_reg, s3b_reg, s4_reg, s5_reg;
    logic [QW-1:0] s_2_reg, s_3_reg, s4b_reg, s3c_reg;
    logic [QW-1:0] s2_next, s3_next, s4_next, s5_next;
    logic [MW-1:0] m2, m3, m4, m5;
    mjt_pkg::mode_t m1_reg, m2_reg, m3_reg, m4_reg, m5_reg;

    logic [PW-1:0] pos_sum, neg_sum, poly;
    logic [QW-1:0] p_reg, p_next;

    logic signed [AW-1:0]              prod;
    logic signed [mjt_pkg::DATA_W-1:0] contrib_reg, contrib_next;

    // Entry stage: classify the time and form the leading quotient bit.
    always_comb
    begin
        dt       = time_tick - start;
        end_tick = {1'b0, start} + {1'b0, span};
        at_end   = (dt == span);
        if (span == '0)
            mode_next = mjt_pkg::MODE_FULL;
        else if (time_tick < start)
            mode_next = mjt_pkg::MODE_ZERO;
        else if ({1'b0, time_tick} > end_tick)
            mode_next = mjt_pkg::MODE_FULL;
        else
            mode_next = mjt_pkg::MODE_RAMP;
    end

    always_ff @(posedge clk)
    begin
        rem_c[0]  <= at_end ? '0 : dt;
        quo_c[0]  <= {{FRAC_BITS{1'b0}}, at_end};
        mode_c[0] <= mode_next;
    end

    for (genvar i = 0; i < FRAC_BITS; i++) begin : g_cell
        mjt_div_cell #(
            .FRAC_BITS (FRAC_BITS)
        ) u_cell (
            .clk      (clk),
            .span     (span),
            .rem_in   (rem_c[i]),
            .quo_in   (quo_c[i]),
            .mode_in  (mode_c[i]),
            .rem_out  (rem_c[i+1]),
            .quo_out  (quo_c[i+1]),
            .mode_out (mode_c[i+1])
        );
    end

    // Powers of s, one multiply per stage; every power stays within 0 .. 1.0.
    always_comb
    begin
        m2      = MW'(quo_c[FRAC_BITS]) * MW'(quo_c[FRAC_BITS]);
        s2_next = m2[FRAC_BITS+QW-1:FRAC_BITS];
        m3      = MW'(s2_reg) * MW'(s1_reg);
        s3_next = m3[FRAC_BITS+QW-1:FRAC_BITS];
        m4      = MW'(s3a_reg) * MW'(s_2_reg);
        s4_next = m4[FRAC_BITS+QW-1:FRAC_BITS];
        m5      = MW'(s4_reg) * MW'(s_3_reg);
        s5_next = m5[FRAC_BITS+QW-1:FRAC_BITS];
    end

    always_ff @(posedge clk)
    begin
        s1_reg  <= quo_c[FRAC_BITS];
        s2_reg  <= s2_next;
        m1_reg  <= mode_c[FRAC_BITS];

        s_2_reg <= s1_reg;
        s3a_reg <= s3_next;
        m2_reg  <= m1_reg;

        s_3_reg <= s_2_reg;
        s3b_reg <= s3a_reg;
        s4_reg  <= s4_next;
        m3_reg  <= m2_reg;

        s4b_reg <= s4_reg;
        s3c_reg <= s3b_reg;
        s5_reg  <= s5_next;
        m4_reg  <= m3_reg;

        p_reg   <= p_next;
        m5_reg  <= m4_reg;

        contrib_reg <= contrib_next;
    end

    // The shape polynomial, clamped to 0 .. 1.0.
    always_comb
    begin
        pos_sum = PW'(s3c_reg) * PW'(10) + PW'(s5_reg) * PW'(6);
        neg_sum = PW'(s4b_reg) * PW'(15);
        poly    = pos_sum - neg_sum;
        if (neg_sum >= pos_sum)
            p_next = '0;
        else if (poly > (PW'(1) << FRAC_BITS))
            p_next = QW'(1) << FRAC_BITS;
        else
            p_next = poly[QW-1:0];
    end

    // Scale the amplitude; dropping the low bits of a signed product rounds down.
    always_comb
    begin
        prod = amp * $signed({1'b0, p_reg});
        unique case (m5_reg)
            mjt_pkg::MODE_ZERO: contrib_next = '0;
            mjt_pkg::MODE_FULL: contrib_next = amp;
            mjt_pkg::MODE_RAMP: contrib_next = prod[FRAC_BITS+mjt_pkg::DATA_W-1:FRAC_BITS];
            default:            contrib_next = '0;
        endcase
    end

    assign contrib = contrib_reg;

endmodule
